// ----- hw/rtl/bounded_stack_count_filter_core_defines.svh -----
// Assertion macros used by the bounded stack checker file.
`ifndef BOUNDED_STACK_COUNT_FILTER_CORE_DEFINES_SVH
`define BOUNDED_STACK_COUNT_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSCF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bscf check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSCF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bscf check failed");

`endif

// ----- hw/rtl/bscf_pkg.sv -----
// Types and constants of the bounded stack with count and even-removal.
`timescale 1ns / 1ps
`default_nettype none

package bscf_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned CNT_OUT_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_PUSH        = 2'd0,
    OP_POP         = 2'd1,
    OP_COUNT       = 2'd2,
    OP_REMOVE_EVEN = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POPW,
    S_SCAN,
    S_FILT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [CNT_OUT_W-1:0]     match_count;
    logic [1:0]               status;
    logic [CNT_OUT_W-1:0]     occupancy;
    logic                     is_full;
    logic                     is_empty;
  } out_item_t;

  // Controls from the datapath into the sequencer.
  typedef struct packed {
    logic accept;
    op_e  op;
    logic empty;
    logic resp_free;
  } seq_in_t;

  // Status from the sequencer back to the datapath.
  typedef struct packed {
    state_e state;
    logic   rd_en;
    logic   rvld;
    logic   pass_done;
  } seq_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bounded_stack_count_filter_core.sv -----
// Top level of the bounded LIFO stack with count and even-removal operations.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   in_item_i  (func, operand_value)
//   out       output     out_valid_o / out_stall_i out_item_o (popped_value .. is_empty)
//   cfg       input      cfg_we_i                  cfg_wdata_i (capacity)
//
// Push and a pop on an empty stack pass through EXEC and RESP, pop through EXEC,
// POPW and RESP, count through EXEC, SCAN and RESP, and remove even through EXEC,
// SCAN, FILT and RESP; SCAN and FILT each walk every entry held before the request.
// The walks are set by the single read port of the entry store: one entry per cycle.
// Reset clears occupancy and sets capacity to 64; the store itself is not cleared.
// A stalled result holds in the output register; the next request is taken once
// the current one has placed its result there and the sequencer is back in idle.
`timescale 1ns / 1ps
`default_nettype none

module bounded_stack_count_filter_core import bscf_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_item_t         in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_item_t             out_item_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i
);

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]  top_q, top_d;
  logic [CNT_W-1:0]  wr_q, wr_d;
  logic [CMP_W-1:0]  skip_q, skip_d;
  op_e               func_q;
  logic [DATA_W-1:0] operand_q;
  logic [DATA_W-1:0] res_pop_q, res_pop_d;
  status_e           res_status_q, res_status_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;

  logic              accept;
  logic              resp_free;
  logic [CMP_W-1:0]  cap_ext, depth_ext, eff_cap, top_ext, odd_ext;
  logic              full, empty;
  logic [CNT_W-1:0]  top_m1;

  seq_in_t           seq_in;
  seq_stat_t         stat;
  logic [CNT_W-1:0]  idx;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic              hit;
  logic [CNT_W-1:0]  acc;

  assign in_stall_o = (stat.state != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign resp_free  = !out_valid_q || !out_stall_i;

  assign cap_ext   = CMP_W'(cap_q);
  assign depth_ext = CMP_W'(DEPTH);
  assign eff_cap   = (cap_ext < depth_ext) ? cap_ext : depth_ext;
  assign top_ext   = CMP_W'(top_q);
  assign odd_ext   = CMP_W'(acc);
  assign full      = (top_ext >= eff_cap);
  assign empty     = (top_q == '0);
  assign top_m1    = top_q - CNT_W'(1);

  assign seq_in.accept    = accept;
  assign seq_in.op        = func_q;
  assign seq_in.empty     = empty;
  assign seq_in.resp_free = resp_free;

  bscf_seq #(
    .CNT_W (CNT_W)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (seq_in),
    .top_i  (top_q),
    .stat_o (stat),
    .idx_o  (idx)
  );

  bscf_unit #(
    .CNT_W (CNT_W)
  ) u_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (stat.state == S_EXEC),
    .acc_en_i  (stat.rvld && (stat.state == S_SCAN)),
    .eq_mode_i (func_q == OP_COUNT),
    .data_i    (ram_rdata),
    .operand_i (operand_q),
    .hit_o     (hit),
    .acc_o     (acc)
  );

  assign ram_raddr = (stat.state == S_EXEC) ? top_m1[ADDR_W-1:0] : idx[ADDR_W-1:0];

  bscf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (stat.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    top_d        = top_q;
    wr_d         = wr_q;
    skip_d       = skip_q;
    res_pop_d    = res_pop_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_item_d   = out_item_q;
    ram_we       = 1'b0;
    ram_waddr    = top_q[ADDR_W-1:0];
    ram_wdata    = operand_q;
    case (stat.state)
      S_EXEC: begin
        res_pop_d    = '0;
        res_status_d = ST_OK;
        case (func_q)
          OP_PUSH: begin
            if (full) begin
              res_status_d = ST_FULL;
            end else begin
              ram_we = 1'b1;
              top_d  = top_q + CNT_W'(1);
            end
          end
          OP_POP: begin
            if (empty) res_status_d = ST_EMPTY;
          end
          default: ;
        endcase
      end
      S_POPW: begin
        res_pop_d = ram_rdata;
        top_d     = top_m1;
      end
      S_SCAN: begin
        // Drop the lowest odd entries that would not fit under capacity.
        if (stat.pass_done && func_q == OP_REMOVE_EVEN) begin
          skip_d = (odd_ext > eff_cap) ? (odd_ext - eff_cap) : '0;
          wr_d   = '0;
        end
      end
      S_FILT: begin
        if (stat.rvld && hit) begin
          if (skip_q != '0) begin
            skip_d = skip_q - CMP_W'(1);
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wr_q[ADDR_W-1:0];
            ram_wdata = ram_rdata;
            wr_d      = wr_q + CNT_W'(1);
          end
        end
        if (stat.pass_done) top_d = wr_q;
      end
      S_RESP: begin
        if (resp_free) begin
          out_valid_d             = 1'b1;
          out_item_d.popped_value = res_pop_q;
          out_item_d.match_count  = (func_q == OP_COUNT) ? CNT_OUT_W'(acc) : '0;
          out_item_d.status       = res_status_q;
          out_item_d.occupancy    = CNT_OUT_W'(top_q);
          out_item_d.is_full      = full;
          out_item_d.is_empty     = empty;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CAP_RESET;
      top_q        <= '0;
      wr_q         <= '0;
      skip_q       <= '0;
      func_q       <= OP_PUSH;
      res_status_q <= ST_OK;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (accept) func_q <= op_e'(in_item_i.func);
      top_q        <= top_d;
      wr_q         <= wr_d;
      skip_q       <= skip_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) operand_q <= in_item_i.operand_value;
    res_pop_q  <= res_pop_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bscf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bscf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bscf_unit.sv -----
// Shared compare unit: equality or odd test on one entry, with match counter.
`timescale 1ns / 1ps
`default_nettype none

module bscf_unit import bscf_pkg::*; #(
  parameter int unsigned CNT_W = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              clr_i,
  input  wire logic              acc_en_i,
  input  wire logic              eq_mode_i,
  input  wire logic [DATA_W-1:0] data_i,
  input  wire logic [DATA_W-1:0] operand_i,
  output logic                   hit_o,
  output logic [CNT_W-1:0]       acc_o
);

  logic [CNT_W-1:0] acc_q, acc_d;

  // Equality for count, lowest bit for the odd test.
  assign hit_o = eq_mode_i ? (data_i == operand_i) : data_i[0];

  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (acc_en_i && hit_o) begin
      acc_d = acc_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bscf_seq.sv -----
// Sequencer: operation state machine and store walk counter.
`timescale 1ns / 1ps
`default_nettype none

module bscf_seq import bscf_pkg::*; #(
  parameter int unsigned CNT_W = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire seq_in_t          ctl_i,
  input  wire logic [CNT_W-1:0] top_i,
  output seq_stat_t             stat_o,
  output logic [CNT_W-1:0]      idx_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             rvld_q, rvld_d;
  logic             rd_more;
  logic             pass_done;
  logic             walking;

  assign rd_more   = (idx_q != top_i);
  assign pass_done = !rd_more && !rvld_q;
  assign walking   = (state_q == S_SCAN) || (state_q == S_FILT);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (ctl_i.accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (ctl_i.op)
          OP_PUSH:                  state_d = S_RESP;
          OP_POP:                   state_d = ctl_i.empty ? S_RESP : S_POPW;
          OP_COUNT, OP_REMOVE_EVEN: state_d = S_SCAN;
          default:                  state_d = S_RESP;
        endcase
      end
      S_POPW: state_d = S_RESP;
      S_SCAN: begin
        if (pass_done) state_d = (ctl_i.op == OP_REMOVE_EVEN) ? S_FILT : S_RESP;
      end
      S_FILT: begin
        if (pass_done) state_d = S_RESP;
      end
      S_RESP: begin
        if (ctl_i.resp_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    stat_o.state     = state_q;
    stat_o.rvld      = rvld_q;
    stat_o.pass_done = pass_done;
    stat_o.rd_en     = 1'b0;
    unique case (state_q)
      S_EXEC:         stat_o.rd_en = (ctl_i.op == OP_POP) && !ctl_i.empty;
      S_SCAN, S_FILT: stat_o.rd_en = rd_more;
      default:        stat_o.rd_en = 1'b0;
    endcase
  end

  // Walk counter: restart at the head of each pass.
  always_comb begin
    idx_d  = idx_q;
    rvld_d = walking && rd_more;
    if (state_q == S_EXEC || (state_q == S_SCAN && pass_done)) begin
      idx_d = '0;
    end else if (walking && rd_more) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      rvld_q  <= rvld_d;
    end
  end

  assign idx_o = idx_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bscf_checker.sv -----
// Port-level checker for the bounded stack core and its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_stack_count_filter_core_defines.svh"

module bscf_checker import bscf_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o
);

  `BSCF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))
  `BSCF_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `BSCF_ASSERT_IMP(a_empty_flag, clk_i, rst_ni, out_valid_o, out_item_o.is_empty == (out_item_o.occupancy == '0))
  `BSCF_ASSERT_IMP(a_reject_full, clk_i, rst_ni, out_valid_o && out_item_o.status == ST_FULL, out_item_o.is_full)
  `BSCF_ASSERT_IMP(a_pop_empty, clk_i, rst_ni, out_valid_o && out_item_o.status == ST_EMPTY, out_item_o.is_empty && out_item_o.popped_value == '0)

endmodule

bind bounded_stack_count_filter_core bscf_checker u_bscf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
